### hw/rtl/sptd_pkg.sv
package sptd_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int MAX_HEIGHT      = 4096;
  localparam int TABLE_SPAN      = 512;
  localparam int TBL_IDX_W       = $clog2(TABLE_SPAN);
  localparam int TBL_DEPTH       = 4 * TABLE_SPAN;
  localparam int TBL_ADDR_W      = $clog2(TBL_DEPTH);
  localparam int PIX_W           = 8;
  localparam int PLANE_WIDTH_W   = 12;
  localparam int PLANE_HEIGHT_W  = 13;
  localparam int ROW_W           = 12;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 13;
  localparam int IN_QUEUE_DEPTH  = 4;
  localparam int OUT_QUEUE_DEPTH = 4;

  localparam logic [PLANE_WIDTH_W-1:0]  PLANE_WIDTH_RST  = 12'd720;
  localparam logic [PLANE_HEIGHT_W-1:0] PLANE_HEIGHT_RST = 13'd576;
  localparam logic [TBL_IDX_W-1:0]      DIFF_BIAS        = TBL_IDX_W'(256);

  localparam logic TBL_SPATIAL  = 1'b0;
  localparam logic TBL_TEMPORAL = 1'b1;

  typedef enum logic {
    ITEM_PIXEL = 1'b0,
    ITEM_TABLE = 1'b1
  } item_kind_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PLANE_WIDTH  = 2'd0,
    REG_PLANE_HEIGHT = 2'd1,
    REG_CHROMA_PLANE = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    item_kind_e            kind;
    logic [PIX_W-1:0]      pix;
    logic [PIX_W-1:0]      prv;
    logic [TBL_ADDR_W-1:0] taddr;
    logic [PIX_W-1:0]      tval;
    logic                  first_col;
    logic                  first_row;
    logic                  chroma;
    logic                  frame_end;
  } sptd_entry_t;

  // lowpass table index: p - c + bias, always inside the 9-bit span
  function automatic logic [TBL_IDX_W-1:0] diff_idx(logic [PIX_W-1:0] p, logic [PIX_W-1:0] c);
    diff_idx = {1'b0, p} + DIFF_BIAS - {1'b0, c};
  endfunction

endpackage

### hw/rtl/sptd_queue.sv
module sptd_queue #(
  parameter int DEPTH = sptd_pkg::IN_QUEUE_DEPTH,
  parameter int W     = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [W-1:0]               data_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [W-1:0]               data_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] wrap_inc(logic [PtrW-1:0] p);
    wrap_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### hw/rtl/sptd_front.sv
module sptd_front #(
  parameter int MAX_WIDTH = sptd_pkg::MAX_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sptd_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [sptd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  in_func_i,
  input  logic [sptd_pkg::PIX_W-1:0]            in_pixel_i,
  input  logic [sptd_pkg::PIX_W-1:0]            in_prev_pixel_i,
  input  logic [sptd_pkg::TBL_ADDR_W-1:0]       in_table_address_i,
  input  logic [sptd_pkg::PIX_W-1:0]            in_table_value_i,
  output logic                                  push_o,
  output sptd_pkg::sptd_entry_t                 entry_o,
  output logic [$clog2(MAX_WIDTH)-1:0]          col_o,
  input  logic                                  full_i
);
  import sptd_pkg::*;

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int WReqW = ($clog2(MAX_WIDTH + 1) > PLANE_WIDTH_W) ?
                         $clog2(MAX_WIDTH + 1) : PLANE_WIDTH_W;
  localparam int CW    = WReqW + 1;

  logic [PLANE_WIDTH_W-1:0]  plane_width_q;
  logic [PLANE_HEIGHT_W-1:0] plane_height_q;
  logic                      chroma_plane_q;
  logic [ColW-1:0]           column_q;
  logic [ROW_W-1:0]          row_q;

  logic [CW-1:0]             w_eff, col_next;
  logic [PLANE_HEIGHT_W-1:0] h_eff, row_next;
  logic                      line_end, frame_end, accept, is_pixel;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_pixel   = (item_kind_e'(in_func_i) == ITEM_PIXEL);

  always_comb begin
    if (plane_width_q == '0) begin
      w_eff = CW'(1);
    end else if (CW'(plane_width_q) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(plane_width_q);
    end
    if (plane_height_q == '0) begin
      h_eff = PLANE_HEIGHT_W'(1);
    end else if (plane_height_q > PLANE_HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = PLANE_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = plane_height_q;
    end
  end

  assign col_next  = CW'(column_q) + CW'(1);
  assign row_next  = PLANE_HEIGHT_W'(row_q) + PLANE_HEIGHT_W'(1);
  assign line_end  = (col_next >= w_eff);
  assign frame_end = line_end && (row_next >= h_eff);

  always_comb begin
    entry_o.kind      = item_kind_e'(in_func_i);
    entry_o.pix       = in_pixel_i;
    entry_o.prv       = in_prev_pixel_i;
    entry_o.taddr     = in_table_address_i;
    entry_o.tval      = in_table_value_i;
    entry_o.first_col = (column_q == '0);
    entry_o.first_row = (row_q == '0);
    entry_o.chroma    = chroma_plane_q;
    entry_o.frame_end = frame_end;
  end

  assign col_o  = column_q;
  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_width_q  <= PLANE_WIDTH_RST;
      plane_height_q <= PLANE_HEIGHT_RST;
      chroma_plane_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PLANE_WIDTH:  plane_width_q  <= cfg_data_i[PLANE_WIDTH_W-1:0];
        REG_PLANE_HEIGHT: plane_height_q <= cfg_data_i[PLANE_HEIGHT_W-1:0];
        REG_CHROMA_PLANE: chroma_plane_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // raster position of the next pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      row_q    <= '0;
    end else if (accept && is_pixel) begin
      if (line_end) begin
        column_q <= '0;
        row_q    <= frame_end ? '0 : row_next[ROW_W-1:0];
      end else begin
        column_q <= col_next[ColW-1:0];
      end
    end
  end

endmodule

### hw/rtl/sptd_back.sv
module sptd_back #(
  parameter int MAX_WIDTH = sptd_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  sptd_pkg::sptd_entry_t        q_entry_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [sptd_pkg::PIX_W-1:0]   out_filtered_o,
  output logic                         out_frame_end_o
);
  import sptd_pkg::*;

  localparam int ColW    = $clog2(MAX_WIDTH);
  localparam int OutCntW = $clog2(OUT_QUEUE_DEPTH + 1);
  localparam int OutW    = PIX_W + 1;

  logic [PIX_W-1:0]      tbl_mem [TBL_DEPTH];
  logic [PIX_W-1:0]      line_mem [MAX_WIDTH];

  logic [PIX_W-1:0]      ta_q, tb_q, line_rd_q, left_q, fwd_val_q;
  logic                  fwd_q;
  logic [TBL_ADDR_W-1:0] addr_a, addr_b;

  logic                  p1_v_q, p2_v_q, p3_v_q;
  logic [PIX_W-1:0]      p1_pix_q, p1_prv_q, p2_hor_q, p2_prv_q, p3_ver_q;
  logic                  p1_first_col_q, p1_first_row_q, p1_chroma_q, p1_fend_q;
  logic                  p2_first_row_q, p2_chroma_q, p2_fend_q, p3_fend_q;
  logic [ColW-1:0]       p1_col_q, p2_col_q;

  logic [PIX_W-1:0]      hor, ver, line_val, res;
  logic                  credit_ok, issue, pix_issue, tbl_issue;
  logic [OutCntW-1:0]    out_count;
  logic [OutCntW:0]      pending;
  logic                  out_full, out_empty;
  logic [OutW-1:0]       out_word;

  assign pending   = (OutCntW + 1)'(out_count) + (OutCntW + 1)'(p2_v_q)
                   + (OutCntW + 1)'(p3_v_q);
  assign credit_ok = (pending < (OutCntW + 1)'(OUT_QUEUE_DEPTH));
  assign issue     = q_valid_i && !p1_v_q && ((q_entry_i.kind == ITEM_TABLE) || credit_ok);
  assign pix_issue = issue && (q_entry_i.kind == ITEM_PIXEL);
  assign tbl_issue = issue && (q_entry_i.kind == ITEM_TABLE);
  assign q_pop_o   = issue;

  // horizontal pass
  assign hor      = p1_first_col_q ? p1_pix_q : p1_pix_q + ta_q;
  assign line_val = fwd_q ? fwd_val_q : line_rd_q;
  // vertical pass
  assign ver      = p2_first_row_q ? p2_hor_q : p2_hor_q + ta_q;
  // temporal pass
  assign res      = p3_ver_q + tb_q;

  always_comb begin
    if (p1_v_q) begin
      addr_a = {p1_chroma_q, TBL_SPATIAL, diff_idx(line_val, hor)};
    end else begin
      addr_a = {q_entry_i.chroma, TBL_SPATIAL, diff_idx(left_q, q_entry_i.pix)};
    end
    addr_b = {p2_chroma_q, TBL_TEMPORAL, diff_idx(p2_prv_q, ver)};
  end

  always_ff @(posedge clk_i) begin
    if (tbl_issue) begin
      tbl_mem[q_entry_i.taddr] <= q_entry_i.tval;
    end
    ta_q <= tbl_mem[addr_a];
    tb_q <= tbl_mem[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (p2_v_q) begin
      line_mem[p2_col_q] <= ver;
    end
    line_rd_q <= line_mem[q_col_i];
  end

  always_ff @(posedge clk_i) begin
    if (pix_issue) begin
      p1_pix_q       <= q_entry_i.pix;
      p1_prv_q       <= q_entry_i.prv;
      p1_first_col_q <= q_entry_i.first_col;
      p1_first_row_q <= q_entry_i.first_row;
      p1_chroma_q    <= q_entry_i.chroma;
      p1_fend_q      <= q_entry_i.frame_end;
      p1_col_q       <= q_col_i;
      // line entry being written this edge by the older pixel
      fwd_q          <= p2_v_q && (p2_col_q == q_col_i);
      fwd_val_q      <= ver;
    end
    if (p1_v_q) begin
      p2_hor_q       <= hor;
      p2_prv_q       <= p1_prv_q;
      p2_first_row_q <= p1_first_row_q;
      p2_chroma_q    <= p1_chroma_q;
      p2_fend_q      <= p1_fend_q;
      p2_col_q       <= p1_col_q;
    end
    if (p2_v_q) begin
      p3_ver_q  <= ver;
      p3_fend_q <= p2_fend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      left_q <= '0;
    end else begin
      p1_v_q <= pix_issue;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      if (p1_v_q) begin
        left_q <= hor;
      end
    end
  end

  sptd_queue #(
    .DEPTH (OUT_QUEUE_DEPTH),
    .W     (OutW)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (p3_v_q),
    .data_i  ({p3_fend_q, res}),
    .full_o  (out_full),
    .pop_i   (out_ready_i),
    .data_o  (out_word),
    .empty_o (out_empty),
    .count_o (out_count)
  );

  assign out_valid_o     = !out_empty;
  assign out_filtered_o  = out_word[PIX_W-1:0];
  assign out_frame_end_o = out_word[PIX_W];

  a_stage_spacing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(p1_v_q && p2_v_q))
    else $error("two pixels in adjacent stages");

  a_out_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    p3_v_q |-> !out_full)
    else $error("result word pushed into full output queue");

  a_issue_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_issue |=> p1_v_q && !p2_v_q)
    else $error("issued pixel did not enter first stage");

endmodule

### hw/rtl/spatio_temporal_pixel_denoiser_unit.sv
// 3D low-pass denoiser for one 8-bit plane in raster order. Each s_axis word is
// either a pixel (tuser 0) with its co-located previous-frame result, or a
// coefficient write (tuser 1) into one of four 512-entry tables (luma spatial,
// luma temporal, chroma spatial, chroma temporal). Table words are taken one per
// cycle unless a pixel holds the first filter stage; a pixel waits for the one
// before it to leave that stage, set by the horizontal recurrence: the next
// pixel's spatial table read needs this pixel's horizontal result, and the table
// memory read is registered; tlast marks the last pixel of the plane. A 4-entry
// queue sits between the input classifier and the filter pipeline, and a 4-entry
// queue holds results, so input keeps flowing while m_axis stalls until both
// queues fill. Tables and line store are not cleared by reset: load every table
// entry a plane can hit before its first pixel; the first row of a plane ignores the line store.
module spatio_temporal_pixel_denoiser_unit #(
  parameter int MAX_WIDTH = sptd_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sptd_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [sptd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel, prev_pixel, table_address, table_value, zero pad
  input  logic [39:0]                      s_axis_tdata,
  // func
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // filtered
  output logic [7:0]                       m_axis_tdata,
  output logic                             m_axis_tlast
);
  import sptd_pkg::*;

  localparam int ColW    = $clog2(MAX_WIDTH);
  localparam int EntryW  = $bits(sptd_entry_t);
  localparam int QueueW  = EntryW + ColW;

  logic              fr_push, q_full, q_empty, q_pop;
  sptd_entry_t       fr_entry, q_entry;
  logic [ColW-1:0]   fr_col, q_col;
  logic [QueueW-1:0] q_word;
  logic [$clog2(IN_QUEUE_DEPTH+1)-1:0] q_count;

  sptd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .in_func_i          (s_axis_tuser),
    .in_pixel_i         (s_axis_tdata[7:0]),
    .in_prev_pixel_i    (s_axis_tdata[15:8]),
    .in_table_address_i (s_axis_tdata[26:16]),
    .in_table_value_i   (s_axis_tdata[34:27]),
    .push_o             (fr_push),
    .entry_o            (fr_entry),
    .col_o              (fr_col),
    .full_i             (q_full)
  );

  sptd_queue #(
    .DEPTH (IN_QUEUE_DEPTH),
    .W     (QueueW)
  ) u_in_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .data_i  ({fr_col, fr_entry}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_word),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  assign q_entry = sptd_entry_t'(q_word[EntryW-1:0]);
  assign q_col   = q_word[QueueW-1:EntryW];

  sptd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (!q_empty),
    .q_entry_i       (q_entry),
    .q_col_i         (q_col),
    .q_pop_o         (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_filtered_o  (m_axis_tdata),
    .out_frame_end_o (m_axis_tlast)
  );

  a_queue_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> (q_count == '0))
    else $error("input queue empty with nonzero count");

  a_queue_flow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_full && !q_pop) |=> !fr_push || q_full)
    else $error("input queue lost its full state without a pop");

  a_no_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("filter pipeline took a word from an empty queue");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import sptd_pkg::*;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  pix;
    logic [7:0]  prv;
    logic [10:0] taddr;
    logic [8:0]  tval;
  } stream_word_t;

  typedef struct packed {
    logic [7:0] filtered;
    logic       frame_end;
  } den_result_t;

  // table differences reachable by the generated pixels
  localparam int DIFF_WIN = 24;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [39:0]            s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;
  logic                   m_axis_tlast;

  // filter state mirror
  logic [8:0]          coef_mem [TBL_DEPTH];
  logic [7:0]          line_mem [MAX_WIDTH_DEF];
  logic [7:0]          left_pix = '0;
  int unsigned         col_pos = 0;
  int unsigned         row_pos = 0;
  logic [11:0]         width_reg = PLANE_WIDTH_RST;
  logic [12:0]         height_reg = PLANE_HEIGHT_RST;
  logic                chroma_reg = 1'b0;

  stream_word_t        tx_words[$];
  stream_word_t        cur_word;
  den_result_t         denoised_q[$];
  den_result_t         rx_expected;
  int unsigned         pushed_cnt = 0;
  int unsigned         accepted_cnt = 0;
  int                  err_cnt = 0;
  int                  tx_idle_pct = 9;
  int                  rx_idle_pct = 69;
  logic                hold_armed = 1'b0;
  logic                hold_done = 1'b0;
  int                  hold_left = 0;
  int                  px_base = 128;

  spatio_temporal_pixel_denoiser_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] lowpass(logic [10:0] base, logic [7:0] p, logic [7:0] c);
    logic [10:0] idx;
    idx = base + 11'(p) + 11'd256 - 11'(c);
    return c + coef_mem[idx][7:0];
  endfunction

  task automatic denoise_pixel(input stream_word_t w);
    int unsigned wd;
    int unsigned ht;
    int unsigned col;
    logic [10:0] sp;
    logic [10:0] tp;
    logic [7:0]  hor;
    logic [7:0]  ver;
    den_result_t r;
    wd = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg);
    ht = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    sp = chroma_reg ? 11'(2 * TABLE_SPAN) : 11'd0;
    tp = sp + 11'(TABLE_SPAN);
    col = (col_pos < MAX_WIDTH_DEF) ? col_pos : MAX_WIDTH_DEF - 1;
    hor = (col_pos == 0) ? w.pix : lowpass(sp, left_pix, w.pix);
    ver = (row_pos == 0) ? hor : lowpass(sp, line_mem[col], hor);
    line_mem[col] = ver;
    left_pix = hor;
    r.filtered = lowpass(tp, w.prv, ver);
    r.frame_end = 1'b0;
    if (col_pos + 1 >= wd) begin
      col_pos = 0;
      if (row_pos + 1 >= ht) begin
        row_pos = 0;
        r.frame_end = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    denoised_q.push_back(r);
  endtask

  // word driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      if (cur_word.kind == ITEM_TABLE) begin
        coef_mem[cur_word.taddr] = cur_word.tval;
      end else begin
        denoise_pixel(cur_word);
      end
      accepted_cnt++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (rst_ni && tx_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        cur_word = tx_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cur_word.kind;
        s_axis_tdata <= {4'b0, cur_word.tval, cur_word.taddr, cur_word.prv, cur_word.pix};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with one long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (denoised_q.size() == 0) begin
        $display("%0t: unexpected word, filtered %0d last %0b", $time, m_axis_tdata,
                 m_axis_tlast);
        err_cnt++;
      end else begin
        rx_expected = denoised_q.pop_front();
        if (m_axis_tdata !== rx_expected.filtered) begin
          $display("%0t: filtered mismatch, expected %0d actual %0d", $time,
                   rx_expected.filtered, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tlast !== rx_expected.frame_end) begin
          $display("%0t: frame end mismatch, expected %0b actual %0b", $time,
                   rx_expected.frame_end, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  function automatic void push_coef(logic [10:0] addr, logic [8:0] val);
    stream_word_t w;
    w = '0;
    w.kind = ITEM_TABLE;
    w.taddr = addr;
    w.tval = val;
    tx_words.push_back(w);
    pushed_cnt++;
  endfunction

  function automatic void push_pixel(logic [7:0] pix, logic [7:0] prv);
    stream_word_t w;
    w = '0;
    w.kind = ITEM_PIXEL;
    w.pix = pix;
    w.prv = prv;
    tx_words.push_back(w);
    pushed_cnt++;
  endfunction

  function automatic logic [8:0] small_coef();
    return 9'(int'($urandom_range(0, 6)) - 3);
  endfunction

  function automatic logic [10:0] window_addr(int tbl, int d);
    return 11'(tbl * TABLE_SPAN + 256 + d);
  endfunction

  function automatic void push_window_coef();
    int tbl;
    int d;
    tbl = int'($urandom_range(0, 3));
    d = int'($urandom_range(0, 2 * DIFF_WIN)) - DIFF_WIN;
    push_coef(window_addr(tbl, d), small_coef());
  endfunction

  function automatic void new_base();
    px_base = int'($urandom_range(20, 235));
  endfunction

  // pixels scatter around one level so table indexes stay inside the loaded window
  function automatic void push_noisy_pixel();
    int n;
    n = px_base + int'($urandom_range(0, 12)) - 6;
    push_pixel(8'(n), 8'(n + int'($urandom_range(0, 8)) - 4));
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_PLANE_WIDTH:  width_reg = val[11:0];
      REG_PLANE_HEIGHT: height_reg = val;
      REG_CHROMA_PLANE: chroma_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_idling(int tx_pct, int rx_pct);
    @(negedge clk_i);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // table words leave no result, so allow the pipeline to settle
  task automatic drain();
    while (accepted_cnt != pushed_cnt) @(posedge clk_i);
    while (denoised_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  initial begin
    int wd;
    int ht;
    int frames;
    int sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // every table entry in the window the generated pixels reach is loaded before any pixel
    for (int t = 0; t < 4; t++) begin
      for (int d = -DIFF_WIN; d <= DIFF_WIN; d++) push_coef(window_addr(t, d), small_coef());
    end
    drain();

    // single pixel planes: temporal pass only, pixel extremes and wrapping
    write_reg(REG_PLANE_WIDTH, 13'd1);
    write_reg(REG_PLANE_HEIGHT, 13'd1);
    write_reg(REG_CHROMA_PLANE, 13'd0);
    push_coef(11'd1023, 9'h1ff);
    push_pixel(8'd0, 8'd255);
    push_coef(11'd513, 9'h001);
    push_pixel(8'd255, 8'd0);
    push_coef(11'd640, 9'h100);
    push_pixel(8'd128, 8'd0);
    push_pixel(8'd0, 8'd0);
    push_pixel(8'd255, 8'd255);
    drain();
    write_reg(REG_CHROMA_PLANE, 13'd1);
    push_coef(11'd2047, 9'h0ff);
    push_pixel(8'd0, 8'd255);
    push_pixel(8'd255, 8'd255);
    drain();

    // table write inside a frame
    write_reg(REG_CHROMA_PLANE, 13'd0);
    write_reg(REG_PLANE_WIDTH, 13'd3);
    write_reg(REG_PLANE_HEIGHT, 13'd2);
    new_base();
    repeat (3) push_noisy_pixel();
    push_window_coef();
    repeat (3) push_noisy_pixel();
    drain();

    // zero sizes act as one
    write_reg(REG_CHROMA_PLANE, 13'd1);
    write_reg(REG_PLANE_WIDTH, 13'd0);
    write_reg(REG_PLANE_HEIGHT, 13'd0);
    repeat (3) push_noisy_pixel();
    drain();

    // sizes shrunk in the middle of a frame
    write_reg(REG_CHROMA_PLANE, 13'd0);
    write_reg(REG_PLANE_WIDTH, 13'd5);
    write_reg(REG_PLANE_HEIGHT, 13'd4);
    new_base();
    repeat (12) push_noisy_pixel();
    drain();
    write_reg(REG_PLANE_WIDTH, 13'd2);
    write_reg(REG_PLANE_HEIGHT, 13'd2);
    push_noisy_pixel();
    drain();

    for (int m = 0; m < 3; m++) begin
      if (m == 1) begin
        set_idling(69, 9);
      end else if (m == 2) begin
        set_idling(0, 0);
        hold_armed = 1'b1;
        // sender keeps offering while the receiver holds off
        write_reg(REG_PLANE_WIDTH, 13'd8);
        write_reg(REG_PLANE_HEIGHT, 13'd4);
        new_base();
        repeat (32) push_noisy_pixel();
        drain();
      end
      sent = 0;
      while (sent < 250) begin
        wd = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        ht = (wd > 16) ? $urandom_range(1, 3) : $urandom_range(1, 8);
        write_reg(REG_PLANE_WIDTH, 13'(wd));
        write_reg(REG_PLANE_HEIGHT, 13'(ht));
        write_reg(REG_CHROMA_PLANE, 13'($urandom_range(0, 1)));
        new_base();
        frames = $urandom_range(1, 3);
        for (int k = 0; k < frames * wd * ht; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            push_window_coef();
            sent++;
          end
          push_noisy_pixel();
          sent++;
        end
        drain();
      end
    end

    if (err_cnt == 0) begin
      $display("spatio_temporal_pixel_denoiser_unit test passed");
    end else begin
      $display("spatio_temporal_pixel_denoiser_unit test failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("spatio_temporal_pixel_denoiser_unit test failed");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sptd_pkg.sv
hw/rtl/sptd_queue.sv
hw/rtl/sptd_front.sv
hw/rtl/sptd_back.sv
hw/rtl/spatio_temporal_pixel_denoiser_unit.sv
tb/tb.sv
